/* hw/rtl/mpct_pkg.sv */
// Package for the mouse packet cursor tracker.
// Holds shared widths, header bit positions, reset constants, the framing phase type,
// the framing state type and the register index codes. No dependencies.
package mpct_pkg;

    // Field and register widths.
    localparam int BYTE_WIDTH     = 8;
    localparam int LIMIT_WIDTH    = 12;
    localparam int OUT_WIDTH      = 12;
    localparam int POS_WIDTH_DEF  = 12;

    // Header bit positions.
    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_XSIGN_BIT  = 4;
    localparam int HDR_YSIGN_BIT  = 5;

    // Reset values.
    localparam logic [LIMIT_WIDTH-1:0] X_LIMIT_RESET = 12'd79;
    localparam logic [LIMIT_WIDTH-1:0] Y_LIMIT_RESET = 12'd24;
    localparam int CURSOR_X_RESET = 40;
    localparam int CURSOR_Y_RESET = 12;

    // Packet framing phase.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XBYTE  = 2'd1,
        PH_YBYTE  = 2'd2
    } phase_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    // Packet framing state passed between the top level and the update logic.
    typedef struct packed {
        phase_t                phase;
        logic [BYTE_WIDTH-1:0] header;
        logic [BYTE_WIDTH-1:0] x_delta;
    } frame_t;

endpackage

/* hw/rtl/mouse_packet_cursor_tracker.sv */
// Mouse packet cursor tracker: frames three-byte mouse packets and updates a clamped cursor.
// Throughput: one byte per cycle while no result is stuck; a byte is registered, then processed from that register.
// A result is valid once the last packet byte has passed the input register and the output register.
// The output register stalls the input register only when a result is pending and not taken.
// Reset: phase awaits a header, cursor at column 40 row 12, limits 79 and 24.
// Depends on mpct_pkg and mpct_update.
module mouse_packet_cursor_tracker import mpct_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   aux_flag,
    input  logic [BYTE_WIDTH-1:0]  data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_WIDTH-1:0]   pos_x,
    output logic [OUT_WIDTH-1:0]   pos_y,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_reg_t               cfg_index,
    input  logic [LIMIT_WIDTH-1:0] cfg_data
);

    localparam int CW = ((POS_WIDTH > LIMIT_WIDTH) ? POS_WIDTH : LIMIT_WIDTH) + 2;

    logic                   in_valid_reg;
    logic [BYTE_WIDTH-1:0]  in_byte_reg;
    frame_t                 frame_reg;
    frame_t                 frame_next;
    logic [POS_WIDTH-1:0]   cursor_x_reg;
    logic [POS_WIDTH-1:0]   cursor_y_reg;
    logic [POS_WIDTH-1:0]   cursor_x_next;
    logic [POS_WIDTH-1:0]   cursor_y_next;
    logic [LIMIT_WIDTH-1:0] x_limit_reg;
    logic [LIMIT_WIDTH-1:0] y_limit_reg;
    logic                   out_valid_reg;
    logic [OUT_WIDTH-1:0]   out_x_reg;
    logic [OUT_WIDTH-1:0]   out_y_reg;
    logic [OUT_WIDTH-1:0]   out_x_next;
    logic [OUT_WIDTH-1:0]   out_y_next;
    logic [CW-1:0]          x_wide;
    logic [CW-1:0]          y_wide;
    logic                   emit;
    logic                   process;

    // Per-byte framing and cursor arithmetic.
    mpct_update #(
        .POS_WIDTH (POS_WIDTH)
    ) u_update (
        .frame_cur (frame_reg),
        .data_byte (in_byte_reg),
        .cursor_x  (cursor_x_reg),
        .cursor_y  (cursor_y_reg),
        .x_limit   (x_limit_reg),
        .y_limit   (y_limit_reg),
        .frame_nxt (frame_next),
        .emit      (emit),
        .new_x     (cursor_x_next),
        .new_y     (cursor_y_next)
    );

    // A registered byte is processed unless it completes a packet while a result is stuck.
    assign process  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    // Resize the new cursor to the output field width.
    assign x_wide     = {{(CW-POS_WIDTH){1'b0}}, cursor_x_next};
    assign y_wide     = {{(CW-POS_WIDTH){1'b0}}, cursor_y_next};
    assign out_x_next = x_wide[OUT_WIDTH-1:0];
    assign out_y_next = y_wide[OUT_WIDTH-1:0];

    // Input register; bytes not from the mouse channel are dropped at the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid && aux_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    // Framing and cursor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.phase   <= PH_HEADER;
            frame_reg.header  <= '0;
            frame_reg.x_delta <= '0;
            cursor_x_reg      <= POS_WIDTH'(CURSOR_X_RESET);
            cursor_y_reg      <= POS_WIDTH'(CURSOR_Y_RESET);
        end
        else if (process)
        begin
            frame_reg <= frame_next;
            if (emit)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = out_x_reg;
    assign pos_y     = out_y_reg;

endmodule

/* hw/rtl/mpct_update.sv */
// Combinational packet framing and cursor update for one mouse byte.
// Depends on mpct_pkg for the frame type, header bit positions and widths.
module mpct_update import mpct_pkg::*; #(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  frame_t                 frame_cur,
    input  logic [BYTE_WIDTH-1:0]  data_byte,
    input  logic [POS_WIDTH-1:0]   cursor_x,
    input  logic [POS_WIDTH-1:0]   cursor_y,
    input  logic [LIMIT_WIDTH-1:0] x_limit,
    input  logic [LIMIT_WIDTH-1:0] y_limit,
    output frame_t                 frame_nxt,
    output logic                   emit,
    output logic [POS_WIDTH-1:0]   new_x,
    output logic [POS_WIDTH-1:0]   new_y
);

    // Working width: holds the cursor plus a 9-bit delta, and any limit.
    localparam int CW = ((POS_WIDTH > LIMIT_WIDTH) ? POS_WIDTH : LIMIT_WIDTH) + 2;

    // Clamp a signed sum to 0..limit, with the limit saturated to the cursor range.
    function automatic logic [POS_WIDTH-1:0] clamp_pos(
        input logic signed [CW-1:0]   v,
        input logic [LIMIT_WIDTH-1:0] limit
    );
        logic signed [CW-1:0] lim_ext;
        logic signed [CW-1:0] mask_ext;
        logic signed [CW-1:0] lim_sat;
        logic signed [CW-1:0] res;
        lim_ext  = $signed({{(CW-LIMIT_WIDTH){1'b0}}, limit});
        mask_ext = $signed({{(CW-POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}});
        lim_sat  = (lim_ext > mask_ext) ? mask_ext : lim_ext;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > lim_sat)
        begin
            res = lim_sat;
        end
        else
        begin
            res = v;
        end
        return res[POS_WIDTH-1:0];
    endfunction

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;

    // Sign-extend the deltas with the header sign bits as the ninth bit.
    assign dx = $signed({{(CW-BYTE_WIDTH){frame_cur.header[HDR_XSIGN_BIT]}},
                         frame_cur.x_delta});
    assign dy = $signed({{(CW-BYTE_WIDTH){frame_cur.header[HDR_YSIGN_BIT]}},
                         data_byte});
    assign cx = $signed({{(CW-POS_WIDTH){1'b0}}, cursor_x});
    assign cy = $signed({{(CW-POS_WIDTH){1'b0}}, cursor_y});

    // X moves with dx; screen Y runs opposite to mouse Y.
    assign nx    = cx + dx;
    assign ny    = cy - dy;
    assign new_x = clamp_pos(nx, x_limit);
    assign new_y = clamp_pos(ny, y_limit);

    // Framing: header, X delta, Y delta. A header without the sync bit is dropped.
    always_comb
    begin
        frame_nxt = frame_cur;
        emit      = 1'b0;
        unique case (frame_cur.phase)
            PH_XBYTE:
            begin
                frame_nxt.x_delta = data_byte;
                frame_nxt.phase   = PH_YBYTE;
            end
            PH_YBYTE:
            begin
                frame_nxt.phase = PH_HEADER;
                emit            = 1'b1;
            end
            default:
            begin
                if (data_byte[HDR_SYNC_BIT])
                begin
                    frame_nxt.header = data_byte;
                    frame_nxt.phase  = PH_XBYTE;
                end
                else
                begin
                    frame_nxt.phase = PH_HEADER;
                end
            end
        endcase
    end

endmodule

/* hw/rtl/mpct_checker.sv */
// Port-level checker for the mouse packet cursor tracker, bound to the top level.
// Depends on mpct_pkg for widths, register codes and limit reset values.
module mpct_checker import mpct_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   aux_flag,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [OUT_WIDTH-1:0]   pos_x,
    input logic [OUT_WIDTH-1:0]   pos_y,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input cfg_reg_t               cfg_index,
    input logic [LIMIT_WIDTH-1:0] cfg_data
);

    logic [LIMIT_WIDTH-1:0] x_lim_reg;
    logic [LIMIT_WIDTH-1:0] y_lim_reg;

    // Shadow copies of the limits as written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lim_reg <= X_LIMIT_RESET;
            y_lim_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_LIMIT: x_lim_reg <= cfg_data;
                REG_Y_LIMIT: y_lim_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // A stalled result keeps its position.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y))
        else $error("result changed while stalled");

    // A new result follows a mouse byte transaction taken through the input and output registers.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && aux_flag, 2))
        else $error("result without a mouse byte two cycles earlier");

    // Every reported column respects the column limit.
    a_x_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_x <= x_lim_reg)
        else $error("column beyond limit");

    // Every reported row respects the row limit.
    a_y_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_y <= y_lim_reg)
        else $error("row beyond limit");

endmodule

bind mouse_packet_cursor_tracker mpct_checker u_mpct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .aux_flag  (aux_flag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

/* tb/sv/tb_mouse_packet_cursor_tracker.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the mouse packet cursor tracker.
// Drives mouse and non-mouse bytes and limit writes, predicts each cursor update and checks it.
// Depends on mpct_pkg and the mouse_packet_cursor_tracker RTL.
module tb_mouse_packet_cursor_tracker;
    import mpct_pkg::*;

    localparam int POS_W = POS_WIDTH_DEF;
    localparam int POS_MASK = (1 << POS_W) - 1;
    localparam int RANDOM_PER_PHASE = 106;
    localparam int IDLE_LIMIT = 1000;

    // One expected cursor position.
    typedef struct packed {
        logic [OUT_WIDTH-1:0] x;
        logic [OUT_WIDTH-1:0] y;
    } position_t;

    // Tracks packet framing and the cursor, and holds the positions still to come.
    class cursor_scoreboard;
        position_t              expected_positions[$];
        logic [LIMIT_WIDTH-1:0] x_limit;
        logic [LIMIT_WIDTH-1:0] y_limit;
        phase_t                 phase;
        logic [BYTE_WIDTH-1:0]  header;
        logic [BYTE_WIDTH-1:0]  x_delta;
        logic [POS_W-1:0]       cursor_x;
        logic [POS_W-1:0]       cursor_y;
        int                     errors;

        function new();
            x_limit  = X_LIMIT_RESET;
            y_limit  = Y_LIMIT_RESET;
            phase    = PH_HEADER;
            header   = '0;
            x_delta  = '0;
            cursor_x = POS_W'(CURSOR_X_RESET);
            cursor_y = POS_W'(CURSOR_Y_RESET);
            errors   = 0;
        endfunction

        function void write_limit(cfg_reg_t idx, logic [LIMIT_WIDTH-1:0] value);
            if (idx == REG_X_LIMIT)
                x_limit = value;
            else
                y_limit = value;
        endfunction

        // A limit wider than the cursor saturates at the cursor range.
        function int clamp(int v, logic [LIMIT_WIDTH-1:0] limit);
            int lim;
            lim = (int'(limit) > POS_MASK) ? POS_MASK : int'(limit);
            if (v < 0)
                return 0;
            if (v > lim)
                return lim;
            return v;
        endfunction

        // Advances the framing for one accepted byte and queues a position when a packet ends.
        function void note_byte(logic aux, logic [BYTE_WIDTH-1:0] b);
            int        dx;
            int        dy;
            position_t p;
            if (!aux)
                return;
            case (phase)
                PH_XBYTE:
                begin
                    x_delta = b;
                    phase = PH_YBYTE;
                end
                PH_YBYTE:
                begin
                    dx = $signed({header[HDR_XSIGN_BIT], x_delta});
                    dy = $signed({header[HDR_YSIGN_BIT], b});
                    cursor_x = POS_W'(clamp(int'(cursor_x) + dx, x_limit));
                    cursor_y = POS_W'(clamp(int'(cursor_y) - dy, y_limit));
                    p.x = OUT_WIDTH'(cursor_x);
                    p.y = OUT_WIDTH'(cursor_y);
                    expected_positions.push_back(p);
                    phase = PH_HEADER;
                end
                default:
                begin
                    // A header without the sync bit is dropped to regain framing.
                    if (b[HDR_SYNC_BIT])
                    begin
                        header = b;
                        phase = PH_XBYTE;
                    end
                    else
                        phase = PH_HEADER;
                end
            endcase
        endfunction

        function int pending();
            return expected_positions.size();
        endfunction

        function void flag(string what);
            if (errors < 10)
                $display("[tb] mismatch at %0t: %s", $time, what);
            errors++;
        endfunction

        // Compares one accepted result with the oldest expected position.
        function void check_position(logic [OUT_WIDTH-1:0] x, logic [OUT_WIDTH-1:0] y);
            position_t want;
            if (expected_positions.size() == 0)
            begin
                flag($sformatf("unexpected position x=%0d y=%0d", x, y));
                return;
            end
            want = expected_positions.pop_front();
            if (x !== want.x)
                flag($sformatf("pos_x expected %0d, got %0d", want.x, x));
            if (y !== want.y)
                flag($sformatf("pos_y expected %0d, got %0d", want.y, y));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   aux_flag;
    logic [BYTE_WIDTH-1:0]  data_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [OUT_WIDTH-1:0]   pos_x;
    logic [OUT_WIDTH-1:0]   pos_y;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index;
    logic [LIMIT_WIDTH-1:0] cfg_data;

    cursor_scoreboard sb;
    int idle_cycles = 0;
    int mouse_bytes_sent = 0;
    int sender_quiet = 0;
    int receiver_quiet = 0;

    mouse_packet_cursor_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .aux_flag  (aux_flag),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draws a random wait, with occasional stretches of no waiting.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Sends one byte transaction and records it once accepted.
    task automatic send_byte(logic aux, logic [BYTE_WIDTH-1:0] b);
        int gap;
        gap = draw_wait(sender_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        aux_flag  <= aux;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(aux, b);
        if (aux)
            mouse_bytes_sent++;
    endtask

    task automatic send_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy);
        send_byte(1'b1, hdr);
        send_byte(1'b1, dx);
        send_byte(1'b1, dy);
    endtask

    // Occasionally slips a non-mouse byte into the stream.
    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0)
            send_byte(1'b0, 8'($urandom));
    endtask

    // Holds the sender until every expected position has come, then lets the pipeline settle.
    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes both limits in back-to-back transactions while the block is idle.
    task automatic set_limits(logic [LIMIT_WIDTH-1:0] xl, logic [LIMIT_WIDTH-1:0] yl);
        cfg_valid <= 1'b1;
        cfg_index <= REG_X_LIMIT;
        cfg_data  <= xl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_limit(REG_X_LIMIT, xl);
        cfg_index <= REG_Y_LIMIT;
        cfg_data  <= yl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_limit(REG_Y_LIMIT, yl);
        cfg_valid <= 1'b0;
    endtask

    // Edge cases: ignored bytes, dropped headers, extreme deltas and clamping.
    task automatic run_directed();
        send_byte(1'b0, 8'hFF);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'hF7);
        send_packet(8'h08, 8'h7F, 8'h00);
        send_packet(8'h38, 8'h00, 8'h00);
        send_packet(8'hFF, 8'hFF, 8'h80);
        send_packet(8'h08, 8'hFF, 8'hFF);
        // A non-mouse byte in the middle of a packet must not disturb framing.
        send_byte(1'b1, 8'h18);
        send_byte(1'b0, 8'h00);
        send_byte(1'b1, 8'h01);
        send_byte(1'b1, 8'hFE);
    endtask

    // Mostly well-formed packets, with noise, dropped headers and cut-short packets mixed in.
    task automatic run_random(int target);
        int start;
        int kind;
        start = mouse_bytes_sent;
        while (mouse_bytes_sent - start < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                send_byte(1'b1, 8'($urandom) | 8'h08);
                maybe_noise();
                send_byte(1'b1, 8'($urandom));
                maybe_noise();
                send_byte(1'b1, 8'($urandom));
            end
            else if (kind < 85)
                send_byte(1'b0, 8'($urandom));
            else if (kind < 92)
                send_byte(1'b1, 8'($urandom) & 8'hF7);
            else
            begin
                send_byte(1'b1, 8'($urandom) | 8'h08);
                send_byte(1'b1, 8'($urandom));
            end
        end
    endtask

    // Receiver side: stalls a random number of cycles before taking each result.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(receiver_quiet);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_position(pos_x, pos_y);
    end

    // Counts cycles in which no transaction of any kind completes.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[mouse_packet_cursor_tracker] ERROR");
        $finish;
    end

    // Main sequence: reset, directed items, then random items under several limit settings.
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        aux_flag  = 1'b0;
        data_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_LIMIT;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limits first.
        run_directed();
        run_random(RANDOM_PER_PHASE);

        for (int setting = 0; setting < 7; setting++)
        begin
            drain(4);
            case (setting)
                0: set_limits(12'd4095, 12'd4095);
                1: set_limits(12'd0, 12'd0);
                2: set_limits(12'd1, 12'd4095);
                3: set_limits(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
                4: set_limits(12'd5, 12'd3);
                5: set_limits(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
                default: set_limits(X_LIMIT_RESET, Y_LIMIT_RESET);
            endcase
            run_random(RANDOM_PER_PHASE);
        end

        drain(10);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[mouse_packet_cursor_tracker] OK");
        else
            $display("[mouse_packet_cursor_tracker] ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_update.sv
hw/rtl/mouse_packet_cursor_tracker.sv
hw/rtl/mpct_checker.sv
tb/sv/tb_mouse_packet_cursor_tracker.sv
